>>> hdl/urb_pkg.sv
// Shared types, register offsets and command codes for the UART register block.
package urb_pkg;

    localparam int FIFO_DEPTH_DEF = 16;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 12;
    localparam int DATA_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int IBRD_W     = 10;
    localparam int FBRD_W     = 6;
    localparam int DIV_W      = IBRD_W + FBRD_W;
    localparam int ACC_W      = 20;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Operation codes of an input item
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_LINE  = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd3;

    // Register offsets
    localparam logic [ADDR_W-1:0] OFS_DATA  = 12'h000;
    localparam logic [ADDR_W-1:0] OFS_FLAG  = 12'h018;
    localparam logic [ADDR_W-1:0] OFS_IBRD  = 12'h024;
    localparam logic [ADDR_W-1:0] OFS_FBRD  = 12'h028;
    localparam logic [ADDR_W-1:0] OFS_CTRL  = 12'h030;
    localparam logic [ADDR_W-1:0] OFS_MASK  = 12'h038;
    localparam logic [ADDR_W-1:0] OFS_MSTAT = 12'h040;
    localparam logic [ADDR_W-1:0] OFS_CLEAR = 12'h044;

    // Flag register bits
    localparam int FLAG_TXE_BIT = 7;
    localparam int FLAG_RXF_BIT = 6;
    localparam int FLAG_TXF_BIT = 5;
    localparam int FLAG_RXE_BIT = 4;

    // Status bits sit at bus bits 5:4; bit 0 receive, bit 1 transmit
    localparam int STAT_LSB = 4;
    localparam int STAT_RX  = 0;
    localparam int STAT_TX  = 1;

    // Configuration port register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IBRD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FBRD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL = 2'd2;

    typedef enum logic [4:0] {
        CMD_RD_DATA,
        CMD_RD_FLAG,
        CMD_RD_IBRD,
        CMD_RD_FBRD,
        CMD_RD_CTRL,
        CMD_RD_MASK,
        CMD_RD_MSTAT,
        CMD_RD_NONE,
        CMD_WR_DATA,
        CMD_WR_IBRD,
        CMD_WR_FBRD,
        CMD_WR_CTRL,
        CMD_WR_MASK,
        CMD_WR_CLEAR,
        CMD_WR_NONE,
        CMD_LINE,
        CMD_TICK
    } cmd_kind_t;

    // Decoded command; data carries write data or the line byte in its low bits
    typedef struct packed {
        cmd_kind_t         kind;
        logic [DATA_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic [BYTE_W-1:0] line_byte;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_line;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              byte_dropped;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_t;

endpackage

>>> hdl/urb_chan_if.sv
// Valid/ready channel carrying one payload per transfer.
interface urb_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/urb_front.sv
// Front end: accepts items and decodes operation and offset into a command.
module urb_front (
    urb_chan_if.sink      req,
    input  logic          q_full,
    output logic          push,
    output urb_pkg::cmd_t cmd
);
    import urb_pkg::*;

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    always_comb
    begin
        cmd.data = req.data.write_data;
        case (req.data.operation)
            OP_READ:
            begin
                case (req.data.address)
                    OFS_DATA:  cmd.kind = CMD_RD_DATA;
                    OFS_FLAG:  cmd.kind = CMD_RD_FLAG;
                    OFS_IBRD:  cmd.kind = CMD_RD_IBRD;
                    OFS_FBRD:  cmd.kind = CMD_RD_FBRD;
                    OFS_CTRL:  cmd.kind = CMD_RD_CTRL;
                    OFS_MASK:  cmd.kind = CMD_RD_MASK;
                    OFS_MSTAT: cmd.kind = CMD_RD_MSTAT;
                    default:   cmd.kind = CMD_RD_NONE;
                endcase
            end
            OP_WRITE:
            begin
                case (req.data.address)
                    OFS_DATA:  cmd.kind = CMD_WR_DATA;
                    OFS_IBRD:  cmd.kind = CMD_WR_IBRD;
                    OFS_FBRD:  cmd.kind = CMD_WR_FBRD;
                    OFS_CTRL:  cmd.kind = CMD_WR_CTRL;
                    OFS_MASK:  cmd.kind = CMD_WR_MASK;
                    OFS_CLEAR: cmd.kind = CMD_WR_CLEAR;
                    default:   cmd.kind = CMD_WR_NONE;
                endcase
            end
            OP_LINE:
            begin
                cmd.kind = CMD_LINE;
                cmd.data = {{(DATA_W-BYTE_W){1'b0}}, req.data.line_byte};
            end
            default:
            begin
                cmd.kind = CMD_TICK;
            end
        endcase
    end

endmodule

>>> hdl/urb_cmd_queue.sv
// Two-entry command queue between the front end and the execute stage.
module urb_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  urb_pkg::cmd_t push_cmd,
    input  logic          pop,
    output urb_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);
    import urb_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hdl/urb_back.sv
// Execute stage: register file, rx/tx FIFOs, tx pacing and the result register.
module urb_back #(
    parameter int FIFO_DEPTH = urb_pkg::FIFO_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    urb_chan_if.sink      cfg,
    input  urb_pkg::cmd_t head,
    input  logic          q_empty,
    output logic          pop,
    urb_chan_if.source    rsp
);
    import urb_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(FIFO_DEPTH);
    localparam logic [LVL_W-1:0] LVL_HALF = LVL_W'(FIFO_DEPTH / 2);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    // FIFO storage
    logic [BYTE_W-1:0] rx_mem [FIFO_DEPTH];
    logic [BYTE_W-1:0] tx_mem [FIFO_DEPTH];
    logic [BYTE_W-1:0] rx_rdata_reg;
    logic [BYTE_W-1:0] tx_rdata_reg;
    logic              rx_we;
    logic              rx_re;
    logic              tx_we;
    logic              tx_re;

    // Architectural state
    logic [IBRD_W-1:0] int_div_reg,    int_div_next;
    logic [FBRD_W-1:0] frac_div_reg,   frac_div_next;
    logic              enable_reg,     enable_next;
    logic [LVL_W-1:0]  rx_level_reg,   rx_level_next;
    logic [PTR_W-1:0]  rx_head_reg,    rx_head_next;
    logic [PTR_W-1:0]  rx_tail_reg,    rx_tail_next;
    logic [LVL_W-1:0]  tx_level_reg,   tx_level_next;
    logic [PTR_W-1:0]  tx_head_reg,    tx_head_next;
    logic [PTR_W-1:0]  tx_tail_reg,    tx_tail_next;
    logic [STAT_W-1:0] mask_reg,       mask_next;
    logic [STAT_W-1:0] raw_stat_reg,   raw_stat_next;
    logic [ACC_W-1:0]  acc_reg,        acc_next;

    // Result register
    logic              b_valid_reg,    b_valid_next;
    logic [DATA_W-1:0] b_rdata_reg,    b_rdata_next;
    logic              b_irq_reg,      b_irq_next;
    logic              b_sel_rx_reg;
    logic              b_sel_tx_reg;
    logic              b_drop_reg,     b_drop_next;

    logic              a_fire;
    logic [DIV_W-1:0]  div_q;
    logic [ACC_W:0]    threshold;
    logic [ACC_W:0]    acc_sum;

    assign a_fire    = !q_empty && (!b_valid_reg || rsp.ready);
    assign pop       = a_fire;
    assign cfg.ready = 1'b1;

    // 10 * (int*64 + frac) as 8x + 2x
    assign div_q     = {int_div_reg, frac_div_reg};
    assign threshold = (ACC_W+1)'({div_q, 3'b000}) + (ACC_W+1)'({div_q, 1'b0});
    assign acc_sum   = {1'b0, acc_reg} + (ACC_W+1)'(4);

    always_comb
    begin
        int_div_next  = int_div_reg;
        frac_div_next = frac_div_reg;
        enable_next   = enable_reg;
        rx_level_next = rx_level_reg;
        rx_head_next  = rx_head_reg;
        rx_tail_next  = rx_tail_reg;
        tx_level_next = tx_level_reg;
        tx_head_next  = tx_head_reg;
        tx_tail_next  = tx_tail_reg;
        mask_next     = mask_reg;
        raw_stat_next = raw_stat_reg;
        acc_next      = acc_reg;
        rx_we         = 1'b0;
        rx_re         = 1'b0;
        tx_we         = 1'b0;
        tx_re         = 1'b0;
        b_rdata_next  = '0;
        b_drop_next   = 1'b0;

        if (a_fire)
        begin
            case (head.kind)
                CMD_RD_DATA:
                begin
                    if (rx_level_reg != '0)
                    begin
                        rx_re         = 1'b1;
                        rx_head_next  = (rx_head_reg == PTR_LAST) ? '0 : rx_head_reg + 1'b1;
                        rx_level_next = rx_level_reg - 1'b1;
                    end
                end
                CMD_RD_FLAG:
                begin
                    b_rdata_next[FLAG_TXE_BIT] = (tx_level_reg == '0);
                    b_rdata_next[FLAG_RXF_BIT] = (rx_level_reg == LVL_FULL);
                    b_rdata_next[FLAG_TXF_BIT] = (tx_level_reg == LVL_FULL);
                    b_rdata_next[FLAG_RXE_BIT] = (rx_level_reg == '0);
                end
                CMD_RD_IBRD:
                begin
                    b_rdata_next = DATA_W'(int_div_reg);
                end
                CMD_RD_FBRD:
                begin
                    b_rdata_next = DATA_W'(frac_div_reg);
                end
                CMD_RD_CTRL:
                begin
                    b_rdata_next = DATA_W'(enable_reg);
                end
                CMD_RD_MASK:
                begin
                    b_rdata_next[STAT_LSB +: STAT_W] = mask_reg;
                end
                CMD_RD_MSTAT:
                begin
                    b_rdata_next[STAT_LSB +: STAT_W] = raw_stat_reg & mask_reg;
                end
                CMD_WR_DATA:
                begin
                    if (tx_level_reg != LVL_FULL)
                    begin
                        tx_we         = 1'b1;
                        tx_tail_next  = (tx_tail_reg == PTR_LAST) ? '0 : tx_tail_reg + 1'b1;
                        tx_level_next = tx_level_reg + 1'b1;
                    end
                    else
                    begin
                        b_drop_next = 1'b1;
                    end
                end
                CMD_WR_IBRD:
                begin
                    int_div_next = head.data[IBRD_W-1:0];
                end
                CMD_WR_FBRD:
                begin
                    frac_div_next = head.data[FBRD_W-1:0];
                end
                CMD_WR_CTRL:
                begin
                    enable_next = head.data[0];
                end
                CMD_WR_MASK:
                begin
                    mask_next = head.data[STAT_LSB +: STAT_W];
                end
                CMD_WR_CLEAR:
                begin
                    raw_stat_next = raw_stat_reg & ~head.data[STAT_LSB +: STAT_W];
                end
                CMD_LINE:
                begin
                    if (enable_reg)
                    begin
                        if (rx_level_reg != LVL_FULL)
                        begin
                            rx_we                  = 1'b1;
                            rx_tail_next           = (rx_tail_reg == PTR_LAST) ? '0
                                                     : rx_tail_reg + 1'b1;
                            rx_level_next          = rx_level_reg + 1'b1;
                            raw_stat_next[STAT_RX] = 1'b1;
                        end
                        else
                        begin
                            b_drop_next = 1'b1;
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (enable_reg)
                    begin
                        if (tx_level_reg == '0)
                        begin
                            acc_next = '0;
                        end
                        else if (acc_sum >= threshold)
                        begin
                            acc_next      = '0;
                            tx_re         = 1'b1;
                            tx_head_next  = (tx_head_reg == PTR_LAST) ? '0 : tx_head_reg + 1'b1;
                            tx_level_next = tx_level_reg - 1'b1;
                            if (tx_level_next == LVL_HALF)
                            begin
                                raw_stat_next[STAT_TX] = 1'b1;
                            end
                        end
                        else
                        begin
                            acc_next = acc_sum[ACC_W-1:0];
                        end
                    end
                end
                default:
                begin
                    // unknown offsets and read-only/write-only misses do nothing
                end
            endcase
        end

        if (cfg.valid)
        begin
            case (cfg.data.index)
                CFG_IBRD: int_div_next  = cfg.data.value[IBRD_W-1:0];
                CFG_FBRD: frac_div_next = cfg.data.value[FBRD_W-1:0];
                CFG_CTRL: enable_next   = cfg.data.value[0];
                default:  ;
            endcase
        end

        b_irq_next = |(raw_stat_next & mask_next);

        if (a_fire)
        begin
            b_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            b_valid_next = 1'b0;
        end
        else
        begin
            b_valid_next = b_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_div_reg  <= IBRD_W'(13);
            frac_div_reg <= '0;
            enable_reg   <= 1'b0;
            rx_level_reg <= '0;
            rx_head_reg  <= '0;
            rx_tail_reg  <= '0;
            tx_level_reg <= '0;
            tx_head_reg  <= '0;
            tx_tail_reg  <= '0;
            mask_reg     <= '0;
            raw_stat_reg <= '0;
            acc_reg      <= '0;
            b_valid_reg  <= 1'b0;
            b_sel_rx_reg <= 1'b0;
            b_sel_tx_reg <= 1'b0;
        end
        else
        begin
            int_div_reg  <= int_div_next;
            frac_div_reg <= frac_div_next;
            enable_reg   <= enable_next;
            rx_level_reg <= rx_level_next;
            rx_head_reg  <= rx_head_next;
            rx_tail_reg  <= rx_tail_next;
            tx_level_reg <= tx_level_next;
            tx_head_reg  <= tx_head_next;
            tx_tail_reg  <= tx_tail_next;
            mask_reg     <= mask_next;
            raw_stat_reg <= raw_stat_next;
            acc_reg      <= acc_next;
            b_valid_reg  <= b_valid_next;
            if (a_fire)
            begin
                b_sel_rx_reg <= rx_re;
                b_sel_tx_reg <= tx_re;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_rdata_reg <= b_rdata_next;
            b_irq_reg   <= b_irq_next;
            b_drop_reg  <= b_drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_mem[rx_tail_reg] <= head.data[BYTE_W-1:0];
        end
        if (rx_re)
        begin
            rx_rdata_reg <= rx_mem[rx_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tx_we)
        begin
            tx_mem[tx_tail_reg] <= head.data[BYTE_W-1:0];
        end
        if (tx_re)
        begin
            tx_rdata_reg <= tx_mem[tx_head_reg];
        end
    end

    assign rsp.valid             = b_valid_reg;
    assign rsp.data.read_data    = b_sel_rx_reg ? DATA_W'(rx_rdata_reg) : b_rdata_reg;
    assign rsp.data.irq_line     = b_irq_reg;
    assign rsp.data.tx_valid     = b_sel_tx_reg;
    assign rsp.data.tx_byte      = b_sel_tx_reg ? tx_rdata_reg : '0;
    assign rsp.data.byte_dropped = b_drop_reg;

    a_rx_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_level_reg <= LVL_FULL)
        else $error("rx level above FIFO depth");

    a_tx_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tx_level_reg <= LVL_FULL)
        else $error("tx level above FIFO depth");

    a_send_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        tx_re |-> (a_fire && tx_level_reg != '0 && !rx_re))
        else $error("tx pop without a pending byte");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && b_drop_next) |-> (rx_level_reg == LVL_FULL || tx_level_reg == LVL_FULL))
        else $error("byte dropped while FIFO not full");

    a_irq_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        a_fire |=> (b_irq_reg == |(raw_stat_reg & mask_reg)))
        else $error("irq in result does not match status and mask");

endmodule

>>> hdl/uart_register_block_with_fifos_unit.sv
// UART register block: bus read/write, line receive and tick items, one result per item.
// Sustained rate is one item per clock while results are taken. An accepted item
// is decoded into a command and queued in a two-entry queue; the execute stage
// takes one command per cycle unless a result waits to be taken, updating the rx/tx
// FIFO pointers, levels, status and tx pacing accumulator in that single cycle, and
// loads the result register. The result of an item passes through the queue entry
// and then the result register before it is offered, and the queue keeps taking input
// items while a result waits to be taken, until its two entries are full.
// FIFO reads use registered memory read data that feeds the result directly.
// Configuration writes are taken every cycle.
module uart_register_block_with_fifos_unit #(
    parameter int FIFO_DEPTH = urb_pkg::FIFO_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    urb_chan_if.sink   req,
    urb_chan_if.source rsp,
    urb_chan_if.sink   cfg
);
    import urb_pkg::*;

    cmd_t front_cmd;
    cmd_t q_head;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    urb_front u_front (
        .req    (req),
        .q_full (q_full),
        .push   (push),
        .cmd    (front_cmd)
    );

    urb_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    urb_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .head    (q_head),
        .q_empty (q_empty),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule
